// ===== hdl/psfd_pkg.sv =====
package psfd_pkg;

    localparam int unsigned SYMBOL_W  = 8;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1823;
    localparam logic [TICKS_W-1:0]   TICKS_MAX     = 16'hFFFF;

    localparam logic [SYMBOL_W-1:0] SYM_PAIR_0 = 8'h80;
    localparam logic [SYMBOL_W-1:0] SYM_PAIR_1 = 8'hE0;
    localparam logic [SYMBOL_W-1:0] SYM_PAIR_2 = 8'hF8;
    localparam logic [SYMBOL_W-1:0] SYM_PAIR_3 = 8'hFE;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_BYTE  = 2'd1,
        ST_FRAME = 2'd2,
        ST_ERROR = 2'd3
    } status_t;

    typedef enum logic {
        ACT_SYMBOL = 1'b0,
        ACT_TICK   = 1'b1
    } action_t;

    typedef struct packed {
        action_t               action;
        logic [SYMBOL_W-1:0]   symbol;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [SYMBOL_W-1:0]   data_byte;
    } result_t;

    typedef struct packed {
        logic       known;
        logic [1:0] pair;
    } sym_decode_t;

    function automatic sym_decode_t symbol_decode(input logic [SYMBOL_W-1:0] sym);
        sym_decode_t d;
        d = '{known: 1'b1, pair: 2'd0};
        unique case (sym)
            SYM_PAIR_0: d.pair = 2'd0;
            SYM_PAIR_1: d.pair = 2'd1;
            SYM_PAIR_2: d.pair = 2'd2;
            SYM_PAIR_3: d.pair = 2'd3;
            default:    d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/psfd_in_reg.sv =====
module psfd_in_reg import psfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    input  logic                advance,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/psfd_core.sv =====
module psfd_core import psfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [TIMEOUT_W-1:0]   cfg_timeout,
    input  logic                   advance,
    input  item_t                  item,
    output result_t                result
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [COUNT_W-1:0]   symbol_count_reg;
    logic [COUNT_W-1:0]   symbol_count_next;
    logic [SYMBOL_W-1:0]  shift_byte_reg;
    logic [SYMBOL_W-1:0]  shift_byte_next;
    logic [TICKS_W-1:0]   idle_ticks_reg;
    logic [TICKS_W-1:0]   idle_ticks_next;

    sym_decode_t          dec;
    logic [SYMBOL_W-1:0]  shifted;
    logic [COUNT_W-1:0]   count_inc;
    logic [TICKS_W-1:0]   ticks_inc;
    logic                 close;

    assign dec       = symbol_decode(item.symbol);
    assign shifted   = {shift_byte_reg[SYMBOL_W-3:0], 2'b00};
    assign count_inc = symbol_count_reg + COUNT_W'(1);
    assign ticks_inc = (idle_ticks_reg == TICKS_MAX) ? idle_ticks_reg
                                                     : idle_ticks_reg + TICKS_W'(1);
    assign close     = ticks_inc > timeout_reg;

    always_comb
    begin
        symbol_count_next = symbol_count_reg;
        shift_byte_next   = shift_byte_reg;
        idle_ticks_next   = idle_ticks_reg;
        result            = '{status: ST_NONE, data_byte: '0};
        unique case (item.action)
            ACT_SYMBOL:
            begin
                idle_ticks_next = '0;
                if (!dec.known)
                begin
                    shift_byte_next = shifted;
                    result.status   = ST_ERROR;
                end
                else
                begin
                    shift_byte_next   = shifted | {{(SYMBOL_W-2){1'b0}}, dec.pair};
                    symbol_count_next = count_inc;
                    if (count_inc[1:0] == 2'b00)
                    begin
                        result.status    = ST_BYTE;
                        result.data_byte = shift_byte_next;
                    end
                end
            end
            ACT_TICK:
            begin
                idle_ticks_next = ticks_inc;
                if (close)
                begin
                    symbol_count_next = '0;
                    if (symbol_count_reg[1:0] != 2'b00)
                    begin
                        result.status = ST_ERROR;
                    end
                    else if (symbol_count_reg != '0)
                    begin
                        result.status = ST_FRAME;
                    end
                end
            end
            default:
            begin
                result.status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg      <= TIMEOUT_RESET;
            symbol_count_reg <= '0;
            shift_byte_reg   <= '0;
            idle_ticks_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                timeout_reg <= cfg_timeout;
            end
            if (advance)
            begin
                symbol_count_reg <= symbol_count_next;
                shift_byte_reg   <= shift_byte_next;
                idle_ticks_reg   <= idle_ticks_next;
            end
        end
    end

    a_symbol_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.action == ACT_SYMBOL |=> idle_ticks_reg == '0)
        else $error("idle counter not cleared by symbol");

    a_byte_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.status == ST_BYTE |=> symbol_count_reg[1:0] == 2'b00)
        else $error("byte emitted off a four-symbol boundary");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.action == ACT_TICK |=> idle_ticks_reg != '0)
        else $error("tick left idle counter at zero");

    a_close_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.action == ACT_TICK && close |=> symbol_count_reg == '0)
        else $error("frame close left symbol count");

endmodule

// ===== hdl/psfd_out_reg.sv =====
module psfd_out_reg import psfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  result_t                result,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output result_t                out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== hdl/pulse_symbol_frame_decoder.sv =====
// pulse-width symbol frame decoder
// s_axis carries one request per symbol byte or timer tick: tuser is the action
// (0 symbol, 1 tick), tdata the received byte, ignored for ticks
// m_axis returns exactly one result per request: tuser is the status
// (0 none, 1 byte ready, 2 frame ready, 3 error), tdata the assembled byte
// when status is byte ready, otherwise zero
// cfg_valid/cfg_data write the 16-bit idle timeout; cfg_ready is always high,
// write only while no request is in flight
// a request accepted into the input register is decoded and written to the result register, which drives m_axis
// throughput: one request per cycle while m_axis_tready is high, set by
// the single decode stage between the input register and the result register
// reset clears the counters, the shift byte and both registers' valid flags,
// and loads the idle timeout with 1823
// when m_axis_tready is low the result holds, one more request waits in the
// input register, and s_axis_tready drops once both are full
module pulse_symbol_frame_decoder import psfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SYMBOL_W-1:0]    s_axis_tdata,   // symbol
    input  logic                   s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SYMBOL_W-1:0]    m_axis_tdata,   // data_byte
    output logic [1:0]             m_axis_tuser,   // status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TIMEOUT_W-1:0]   cfg_data
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.action = action_t'(s_axis_tuser);
    assign in_item.symbol = s_axis_tdata;
    assign cfg_ready      = 1'b1;

    psfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    psfd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_timeout (cfg_data),
        .advance     (advance),
        .item        (item),
        .result      (result)
    );

    psfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = out_result.data_byte;
    assign m_axis_tuser = out_result.status;

endmodule
